// ===== hw/rtl/cscan_pkg.sv =====
package cscan_pkg;

    localparam int MAX_REQUESTS_DEF = 32;
    localparam int CYL_BITS_DEF     = 16;

    localparam int CYL_W     = 16;
    localparam int POS_W     = 17;
    localparam int DISK_W    = 17;
    localparam int MOVE_W    = 22;
    localparam int CFG_IDX_W = 2;
    localparam int M_TDATA_W = 40;

    localparam logic [MOVE_W-1:0] MOVE_MAX   = '1;
    localparam logic [DISK_W-1:0] DISK_RESET = 17'd200;

    localparam logic [CFG_IDX_W-1:0] REG_DISK_CYLINDERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_HEAD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_RIGHT    = 2'd2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_T,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_START,
        ST_SIDE,
        ST_DIFF,
        ST_ACC,
        ST_JUMP,
        ST_EMIT,
        ST_TOTAL
    } state_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SWEEP,
        PH_JUMP,
        PH_SECOND
    } phase_t;

    typedef enum logic [2:0] {
        MV_HOLD,
        MV_START,
        MV_DIFF,
        MV_JUMP,
        MV_ACC
    } mv_op_t;

    typedef struct packed {
        mv_op_t             op;
        logic [POS_W-1:0]   tgt;
        logic [POS_W-1:0]   jump_dist;
    } mv_cmd_t;

endpackage

// ===== hw/rtl/cscan_mvu.sv =====
module cscan_mvu (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cscan_pkg::mv_cmd_t             cmd,
    output logic [cscan_pkg::POS_W-1:0]    head,
    output logic [cscan_pkg::MOVE_W-1:0]   movement
);
    import cscan_pkg::*;

    localparam int SUM_W = MOVE_W + 1;

    logic [POS_W-1:0]  head_reg, head_next;
    logic [POS_W-1:0]  dist_reg, dist_next;
    logic [MOVE_W-1:0] mov_reg, mov_next;
    logic [SUM_W-1:0]  sum;

    always_comb begin
        head_next = head_reg;
        dist_next = dist_reg;
        mov_next  = mov_reg;
        sum       = {1'b0, mov_reg} + SUM_W'(dist_reg);
        case (cmd.op)
            MV_START: begin
                head_next = cmd.tgt;
                mov_next  = '0;
            end
            MV_DIFF: begin
                dist_next = (head_reg > cmd.tgt) ? head_reg - cmd.tgt : cmd.tgt - head_reg;
                head_next = cmd.tgt;
            end
            MV_JUMP: begin
                dist_next = cmd.jump_dist;
                head_next = cmd.tgt;
            end
            MV_ACC: begin
                mov_next = sum[MOVE_W] ? MOVE_MAX : sum[MOVE_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            mov_reg  <= '0;
        end else begin
            head_reg <= head_next;
            mov_reg  <= mov_next;
        end
        dist_reg <= dist_next;
    end

    assign head     = head_reg;
    assign movement = mov_reg;

endmodule

// ===== hw/rtl/cscan_disk_scheduler_core.sv =====
// C-SCAN disk request scheduler. Requests stream in on s_ one per cycle and are held
// in an on-chip store of MAX_REQUESTS entries; extra requests are dropped and flagged on
// every result of that batch. The request with s_tlast closes the batch: the block then
// stops taking input, insertion-sorts the store in place through its single read and
// single write port, finds the split at start_head with a scan of the sorted store,
// and serves each stored cylinder in turn (ST_SIDE, ST_DIFF, ST_ACC, ST_EMIT) through one
// shared distance and saturating-accumulate unit, with extra steps for the sweep to the
// disk end and the jump, and to start and to close with the total.
// One result per stored request comes out on m_, then a total result with m_tlast high.
// The output register lets serving go on while a result waits on m_tready; s_tready
// returns once the total result is loaded. Configuration writes are taken at any time
// on the cfg_ channel and should be made only while no batch is being served.
module cscan_disk_scheduler_core #(
    parameter int MAX_REQUESTS = cscan_pkg::MAX_REQUESTS_DEF,
    parameter int CYL_BITS     = cscan_pkg::CYL_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [cscan_pkg::CYL_W-1:0]        s_tdata,   // cylinder
    input  logic                               s_tlast,   // last_request
    input  logic                               s_tvalid,
    output logic                               s_tready,
    output logic [cscan_pkg::M_TDATA_W-1:0]    m_tdata,   // served_cylinder, movement, zero pad
    output logic [1:0]                         m_tuser,   // is_total, dropped
    output logic                               m_tlast,   // end_of_run
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cscan_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cscan_pkg::DISK_W-1:0]       cfg_data
);
    import cscan_pkg::*;

    localparam int IDX_W = $clog2(MAX_REQUESTS);
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_REQUESTS);
    localparam logic [CYL_W-1:0] CYL_MASK =
        (CYL_BITS >= CYL_W) ? '1 : CYL_W'((1 << CYL_BITS) - 1);
    localparam logic [DISK_W-1:0] DISK_MASK =
        (CYL_BITS >= DISK_W - 1) ? '1 : DISK_W'((1 << (CYL_BITS + 1)) - 1);
    localparam logic [DISK_W:0] DISK_LIM =
        (CYL_BITS >= DISK_W) ? '1 : (DISK_W + 1)'(1 << CYL_BITS);

    // config
    logic [DISK_W-1:0] disk_reg;
    logic [CYL_W-1:0]  sh_reg;
    logic              dir_reg;

    // request store
    logic [CYL_W-1:0] store_mem [MAX_REQUESTS];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic [CYL_W-1:0] mem_wdata, rd_data_reg;

    // sequencer
    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [CYL_W-1:0] t_reg, t_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] p_reg, p_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0] n_new;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [CYL_W-1:0]  m_cyl_reg;
    logic [MOVE_W-1:0] m_mov_reg;
    logic              m_total_reg, m_drop_reg;
    logic              out_load, out_total, out_free;

    // move unit
    mv_cmd_t           cmd;
    logic [POS_W-1:0]  head;
    logic [MOVE_W-1:0] movement;

    logic [DISK_W:0]   disk_ext, disk_eff, disk_m1;
    logic [POS_W-1:0]  top_pos;
    logic [IDX_W-1:0]  idx_step;

    cscan_mvu u_mvu (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .head     (head),
        .movement (movement)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_reg <= DISK_RESET;
            sh_reg   <= '0;
            dir_reg  <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DISK_CYLINDERS: disk_reg <= cfg_data & DISK_MASK;
                REG_START_HEAD:     sh_reg   <= cfg_data[CYL_W-1:0] & CYL_MASK;
                REG_SWEEP_RIGHT:    dir_reg  <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign disk_ext = {1'b0, disk_reg};
    assign disk_eff = (disk_reg == '0) ? (DISK_W + 1)'(1)
                    : ((disk_ext > DISK_LIM) ? DISK_LIM : disk_ext);
    assign disk_m1  = disk_eff - (DISK_W + 1)'(1);
    assign top_pos  = disk_m1[POS_W-1:0];
    assign idx_step = dir_reg ? idx_reg + IDX_W'(1) : idx_reg - IDX_W'(1);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= store_mem[mem_raddr];
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        t_next     = t_reg;
        k_next     = k_reg;
        p_next     = p_reg;
        idx_next   = idx_reg;
        left_next  = left_reg;
        n_new      = cnt_reg;
        mem_we     = 1'b0;
        mem_waddr  = j_reg;
        mem_wdata  = t_reg;
        mem_raddr  = idx_reg;
        out_load   = 1'b0;
        out_total  = 1'b0;
        cmd.op        = MV_HOLD;
        cmd.tgt       = '0;
        cmd.jump_dist = '0;
        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    if (cnt_reg < N_MAX) begin
                        mem_we    = 1'b1;
                        mem_waddr = cnt_reg[IDX_W-1:0];
                        mem_wdata = s_tdata & CYL_MASK;
                        cnt_next  = cnt_reg + CNT_W'(1);
                        n_new     = cnt_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        i_next = CNT_W'(1);
                        k_next = '0;
                        p_next = '0;
                        state_next = (n_new > CNT_W'(1)) ? ST_SORT_RD : ST_SCAN_RD;
                    end
                end
            end
            ST_SORT_RD: begin
                mem_raddr  = i_reg[IDX_W-1:0];
                state_next = ST_SORT_T;
            end
            ST_SORT_T: begin
                t_next     = rd_data_reg;
                j_next     = i_reg[IDX_W-1:0];
                mem_raddr  = i_reg[IDX_W-1:0] - IDX_W'(1);
                state_next = ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                if (rd_data_reg > t_reg) begin
                    mem_wdata = rd_data_reg;
                    j_next    = j_reg - IDX_W'(1);
                    mem_raddr = j_reg - IDX_W'(2);
                    if (j_reg == IDX_W'(1)) begin
                        state_next = ST_SORT_PUT;
                    end
                end else begin
                    mem_wdata = t_reg;
                    i_next    = i_reg + CNT_W'(1);
                    k_next    = '0;
                    p_next    = '0;
                    state_next = (i_reg + CNT_W'(1) == cnt_reg) ? ST_SCAN_RD : ST_SORT_RD;
                end
            end
            ST_SORT_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = t_reg;
                i_next    = i_reg + CNT_W'(1);
                k_next    = '0;
                p_next    = '0;
                state_next = (i_reg + CNT_W'(1) == cnt_reg) ? ST_SCAN_RD : ST_SORT_RD;
            end
            ST_SCAN_RD: begin
                mem_raddr  = k_reg[IDX_W-1:0];
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (rd_data_reg < sh_reg) begin
                    p_next = k_reg + CNT_W'(1);
                    k_next = k_reg + CNT_W'(1);
                    state_next = (k_reg + CNT_W'(1) == cnt_reg) ? ST_START : ST_SCAN_RD;
                end else begin
                    p_next     = k_reg;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.op     = MV_START;
                cmd.tgt    = {1'b0, sh_reg};
                phase_next = PH_FIRST;
                if (dir_reg) begin
                    idx_next  = p_reg[IDX_W-1:0];
                    left_next = cnt_reg - p_reg;
                end else begin
                    idx_next  = p_reg[IDX_W-1:0] - IDX_W'(1);
                    left_next = p_reg;
                end
                state_next = ST_SIDE;
            end
            ST_SIDE: begin
                if (left_reg != '0) begin
                    mem_raddr  = idx_reg;
                    idx_next   = idx_step;
                    left_next  = left_reg - CNT_W'(1);
                    state_next = ST_DIFF;
                end else if (phase_reg == PH_FIRST) begin
                    phase_next = PH_SWEEP;
                    state_next = ST_DIFF;
                end else begin
                    state_next = ST_TOTAL;
                end
            end
            ST_DIFF: begin
                cmd.op = MV_DIFF;
                if (phase_reg == PH_SWEEP) begin
                    cmd.tgt = dir_reg ? top_pos : '0;
                end else begin
                    cmd.tgt = {1'b0, rd_data_reg};
                end
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.op = MV_ACC;
                case (phase_reg)
                    PH_SWEEP: begin
                        state_next = ST_JUMP;
                    end
                    PH_JUMP: begin
                        phase_next = PH_SECOND;
                        if (dir_reg) begin
                            idx_next  = '0;
                            left_next = p_reg;
                        end else begin
                            idx_next  = cnt_reg[IDX_W-1:0] - IDX_W'(1);
                            left_next = cnt_reg - p_reg;
                        end
                        state_next = ST_SIDE;
                    end
                    default: begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_JUMP: begin
                cmd.op        = MV_JUMP;
                cmd.jump_dist = top_pos;
                cmd.tgt       = dir_reg ? '0 : top_pos;
                phase_next    = PH_JUMP;
                state_next    = ST_ACC;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_SIDE;
                end
            end
            ST_TOTAL: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_total  = 1'b1;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        m_valid_next = out_load || (m_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        phase_reg <= phase_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        t_reg     <= t_next;
        k_reg     <= k_next;
        p_reg     <= p_next;
        idx_reg   <= idx_next;
        left_reg  <= left_next;
        if (out_load) begin
            m_cyl_reg   <= head[CYL_W-1:0];
            m_mov_reg   <= movement;
            m_total_reg <= out_total;
            m_drop_reg  <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - MOVE_W - CYL_W){1'b0}}, m_mov_reg, m_cyl_reg};
    assign m_tuser  = {m_drop_reg, m_total_reg};
    assign m_tlast  = m_total_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= N_MAX)
        else $error("request count beyond store depth");

    a_close_batch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after last request");

    a_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SIDE) |-> (left_reg <= cnt_reg))
        else $error("side length beyond batch size");

endmodule
